// File: sv/agcm_pkg.sv
// Package for the AES-128-GCM engine: types, codes, S-box and GF helpers.
// No dependencies.
`timescale 1ns / 1ps
package agcm_pkg;

    localparam int BlockWidth = 128;
    localparam int CountWidth = 5;
    localparam int AddrWidth  = 6;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_AAD    = 2'd1,
        CMD_TEXT   = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_SEQUENCE = 2'd1,
        ST_MISMATCH = 2'd2,
        ST_COUNT    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_AAD  = 2'd1,
        PH_TEXT = 2'd2
    } phase_t;

    localparam logic [AddrWidth-1:0] REG_KEY_HIGH   = 6'd0;
    localparam logic [AddrWidth-1:0] REG_KEY_LOW    = 6'd8;
    localparam logic [AddrWidth-1:0] REG_NONCE_HIGH = 6'd16;
    localparam logic [AddrWidth-1:0] REG_NONCE_LOW  = 6'd24;
    localparam logic [AddrWidth-1:0] REG_DECRYPT    = 6'd32;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AES_H,
        S_AES_MASK,
        S_AES_CTR,
        S_MUL,
        S_TAG,
        S_OUT
    } state_t;

    // Datapath operation codes issued by the controller.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_AES_LOAD,
        OP_AES_ROUND,
        OP_MUL_LOAD,
        OP_MUL_STEP
    } op_t;

    typedef enum logic [1:0] {
        AIN_ZERO,
        AIN_MASK,
        AIN_CTR
    } ain_t;

    typedef enum logic [1:0] {
        MIN_AAD,
        MIN_TEXT,
        MIN_LEN
    } min_t;

    typedef struct packed {
        op_t  op;
        ain_t ain;
        min_t min;
        logic save_h;
        logic save_mask;
        logic make_text;
        logic start_msg;
    } dp_cmd_t;

    typedef struct packed {
        logic aes_done;
        logic mul_done;
    } dp_status_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] GhashPoly = 8'he1;
    localparam logic [7:0] AesPoly   = 8'h1b;

    function automatic logic [7:0] dbl8(input logic [7:0] x);
        dbl8 = {x[6:0], 1'b0} ^ (x[7] ? AesPoly : 8'h00);
    endfunction

    // Byte i of a block sits at bits 127-8i down to 120-8i.
    function automatic logic [7:0] get_byte(input logic [127:0] b, input int i);
        get_byte = b[127-8*i -: 8];
    endfunction

    function automatic logic [127:0] keep_mask(input logic [CountWidth-1:0] n);
        logic [127:0] m;
        m = '0;
        for (int i = 0; i < 16; i++) begin
            if (i < int'(n)) begin
                m[127-8*i -: 8] = 8'hff;
            end
        end
        keep_mask = m;
    endfunction

endpackage

// File: sv/agcm_if.sv
// Valid/ready stream interface carrying one payload item.
// Depends on nothing; width is a parameter of the interface.
`timescale 1ns / 1ps
interface agcm_if #(
    parameter int Width = 8
);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/agcm_datapath.sv
// Datapath: AES-128 round unit with on-the-fly key schedule, bit-serial GHASH
// multiplier and message state registers. Depends on agcm_pkg.
`timescale 1ns / 1ps
module agcm_datapath
    import agcm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dp_cmd_t               cmd,
    output dp_status_t            stat,
    input  logic [127:0]          key,
    input  logic [95:0]           nonce,
    input  logic                  decrypt,
    input  logic [127:0]          in_data,
    input  logic [CountWidth-1:0] in_count,
    output logic [127:0]          text_out,
    output logic [127:0]          tag_out
);

    logic [127:0] state_reg, state_next;
    logic [127:0] rkey_reg, rkey_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [3:0]   round_reg, round_next;
    logic [127:0] h_reg, h_next;
    logic [127:0] mask_reg, mask_next;
    logic [127:0] acc_reg, acc_next;
    logic [127:0] z_reg, z_next;
    logic [127:0] v_reg, v_next;
    logic [127:0] a_reg, a_next;
    logic [6:0]   bit_reg, bit_next;
    logic [31:0]  ctr_reg, ctr_next;
    logic [63:0]  aad_tot_reg, aad_tot_next;
    logic [63:0]  text_tot_reg, text_tot_next;
    logic [127:0] text_reg, text_next;

    logic [127:0] aes_in;
    logic [127:0] sub_b, shf_b, mix_b, key_nx, rnd_out;
    logic [127:0] mdata, x_in;
    logic [7:0]   a0, a1, a2, a3, all;

    always_comb
    begin
        unique case (cmd.ain)
            AIN_MASK: aes_in = {nonce, 32'd1};
            AIN_CTR:  aes_in = {nonce, ctr_reg};
            default:  aes_in = '0;
        endcase
        for (int i = 0; i < 16; i++) begin
            sub_b[127-8*i -: 8] = SBOX[get_byte(state_reg, i)];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                shf_b[127-8*(i+4*c) -: 8] = get_byte(sub_b, i + 4*((c+i) & 3));
            end
        end
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(shf_b, 4*c);
            a1 = get_byte(shf_b, 4*c+1);
            a2 = get_byte(shf_b, 4*c+2);
            a3 = get_byte(shf_b, 4*c+3);
            all = a0 ^ a1 ^ a2 ^ a3;
            mix_b[127-32*c -: 8]    = a0 ^ all ^ dbl8(a0 ^ a1);
            mix_b[119-32*c -: 8]    = a1 ^ all ^ dbl8(a1 ^ a2);
            mix_b[111-32*c -: 8]    = a2 ^ all ^ dbl8(a2 ^ a3);
            mix_b[103-32*c -: 8]    = a3 ^ all ^ dbl8(a3 ^ a0);
        end
        key_nx[127:120] = get_byte(rkey_reg, 0) ^ SBOX[get_byte(rkey_reg, 13)] ^ rcon_reg;
        key_nx[119:112] = get_byte(rkey_reg, 1) ^ SBOX[get_byte(rkey_reg, 14)];
        key_nx[111:104] = get_byte(rkey_reg, 2) ^ SBOX[get_byte(rkey_reg, 15)];
        key_nx[103:96]  = get_byte(rkey_reg, 3) ^ SBOX[get_byte(rkey_reg, 12)];
        key_nx[95:64]   = rkey_reg[95:64] ^ key_nx[127:96];
        key_nx[63:32]   = rkey_reg[63:32] ^ key_nx[95:64];
        key_nx[31:0]    = rkey_reg[31:0] ^ key_nx[63:32];
        rnd_out = ((round_reg == 4'd10) ? shf_b : mix_b) ^ key_nx;

        mdata = in_data & keep_mask(in_count);
        unique case (cmd.min)
            MIN_TEXT: x_in = decrypt ? mdata : ((mdata ^ state_reg) & keep_mask(in_count));
            MIN_LEN:  x_in = {aad_tot_reg << 3, text_tot_reg << 3};
            default:  x_in = mdata;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        rkey_next     = rkey_reg;
        rcon_next     = rcon_reg;
        round_next    = round_reg;
        h_next        = h_reg;
        mask_next     = mask_reg;
        acc_next      = acc_reg;
        z_next        = z_reg;
        v_next        = v_reg;
        a_next        = a_reg;
        bit_next      = bit_reg;
        ctr_next      = ctr_reg;
        aad_tot_next  = aad_tot_reg;
        text_tot_next = text_tot_reg;
        text_next     = text_reg;
        unique case (cmd.op)
            OP_AES_LOAD:
            begin
                state_next = aes_in ^ key;
                rkey_next  = key;
                rcon_next  = 8'h01;
                round_next = 4'd1;
            end
            OP_AES_ROUND:
            begin
                state_next = rnd_out;
                rkey_next  = key_nx;
                rcon_next  = dbl8(rcon_reg);
                round_next = round_reg + 4'd1;
            end
            OP_MUL_LOAD:
            begin
                a_next   = acc_reg ^ x_in;
                z_next   = '0;
                v_next   = h_reg;
                bit_next = '0;
                if (cmd.min == MIN_AAD) begin
                    aad_tot_next = aad_tot_reg + 64'(in_count);
                end
                if (cmd.min == MIN_TEXT) begin
                    text_tot_next = text_tot_reg + 64'(in_count);
                    ctr_next      = ctr_reg + 32'd1;
                end
            end
            OP_MUL_STEP:
            begin
                z_next   = a_reg[127] ? (z_reg ^ v_reg) : z_reg;
                v_next   = {1'b0, v_reg[127:1]} ^ (v_reg[0] ? {GhashPoly, 120'd0} : '0);
                a_next   = {a_reg[126:0], 1'b0};
                bit_next = bit_reg + 7'd1;
                if (bit_reg == 7'd127) begin
                    acc_next = a_reg[127] ? (z_reg ^ v_reg) : z_reg;
                end
            end
            default:
            begin
            end
        endcase
        if (cmd.save_h) begin
            h_next = state_reg;
        end
        if (cmd.save_mask) begin
            mask_next = state_reg;
        end
        if (cmd.make_text) begin
            text_next = (mdata ^ state_reg) & keep_mask(in_count);
        end
        if (cmd.start_msg) begin
            acc_next      = '0;
            ctr_next      = 32'd2;
            aad_tot_next  = '0;
            text_tot_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            round_reg    <= '0;
            bit_reg      <= '0;
            h_reg        <= '0;
            mask_reg     <= '0;
            acc_reg      <= '0;
            ctr_reg      <= '0;
            aad_tot_reg  <= '0;
            text_tot_reg <= '0;
        end else begin
            round_reg    <= round_next;
            bit_reg      <= bit_next;
            h_reg        <= h_next;
            mask_reg     <= mask_next;
            acc_reg      <= acc_next;
            ctr_reg      <= ctr_next;
            aad_tot_reg  <= aad_tot_next;
            text_tot_reg <= text_tot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
        rkey_reg  <= rkey_next;
        rcon_reg  <= rcon_next;
        z_reg     <= z_next;
        v_reg     <= v_next;
        a_reg     <= a_next;
        text_reg  <= text_next;
    end

    assign stat.aes_done = (round_reg == 4'd11);
    assign stat.mul_done = (bit_reg == 7'd127) && (cmd.op == OP_MUL_STEP);
    assign text_out      = text_reg;
    assign tag_out       = acc_reg ^ mask_reg;

    a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
        round_reg <= 4'd11)
        else $error("AES round counter out of range");
    a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_MUL_LOAD && cmd.min == MIN_TEXT && !cmd.start_msg)
        |=> ctr_reg == $past(ctr_reg) + 32'd1)
        else $error("Counter did not step on a text chunk");
    a_bit_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_MUL_LOAD) |=> bit_reg == 7'd0)
        else $error("Multiplier did not restart");

endmodule

// File: sv/agcm_ctrl.sv
// Controller state machine: sequences AES and GHASH work, checks command
// order and forms each result transaction. Depends on agcm_pkg.
`timescale 1ns / 1ps
module agcm_ctrl
    import agcm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cmd_t                  in_cmd,
    input  logic [127:0]          in_data,
    input  logic [CountWidth-1:0] in_count,
    input  logic                  decrypt,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [127:0]          out_data,
    output logic [CountWidth-1:0] out_count,
    output logic                  out_tag,
    output status_t               out_status,
    output dp_cmd_t               dcmd,
    input  dp_status_t            dstat,
    input  logic [127:0]          text_out,
    input  logic [127:0]          tag_out,
    output logic [127:0]          hold_data,
    output logic [CountWidth-1:0] hold_count
);

    state_t                state_reg, state_next;
    phase_t                phase_reg, phase_next;
    logic                  partial_reg, partial_next;
    cmd_t                  cmd_reg, cmd_next;
    logic [127:0]          data_reg, data_next;
    logic [CountWidth-1:0] cnt_reg, cnt_next;
    logic [127:0]          res_reg, res_next;
    logic [CountWidth-1:0] rcnt_reg, rcnt_next;
    logic                  rtag_reg, rtag_next;
    status_t               rst_reg, rst_next;
    logic                  seq_bad;
    logic                  cnt_bad;

    always_comb
    begin
        unique case (in_cmd)
            CMD_AAD:    seq_bad = (phase_reg != PH_AAD) || partial_reg;
            CMD_TEXT:   seq_bad = (phase_reg == PH_IDLE)
                                  || ((phase_reg == PH_TEXT) && partial_reg);
            CMD_FINISH: seq_bad = (phase_reg == PH_IDLE);
            default:    seq_bad = 1'b0;
        endcase
        cnt_bad = (in_count == '0) || (in_count > 5'd16);
    end

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        partial_next = partial_reg;
        cmd_next     = cmd_reg;
        data_next    = data_reg;
        cnt_next     = cnt_reg;
        res_next     = res_reg;
        rcnt_next    = rcnt_reg;
        rtag_next    = rtag_reg;
        rst_next     = rst_reg;
        dcmd         = '{op: OP_NONE, ain: AIN_ZERO, min: MIN_AAD, save_h: 1'b0,
                         save_mask: 1'b0, make_text: 1'b0, start_msg: 1'b0};
        in_ready     = (state_reg == S_IDLE);
        out_valid    = (state_reg == S_OUT);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    cmd_next  = in_cmd;
                    data_next = in_data;
                    cnt_next  = in_count;
                    res_next  = '0;
                    rcnt_next = '0;
                    rtag_next = 1'b0;
                    rst_next  = ST_OK;
                    if (in_cmd == CMD_START) begin
                        dcmd.op    = OP_AES_LOAD;
                        dcmd.ain   = AIN_ZERO;
                        state_next = S_AES_H;
                    end else if (seq_bad) begin
                        rst_next   = ST_SEQUENCE;
                        state_next = S_OUT;
                    end else if (in_cmd == CMD_FINISH) begin
                        dcmd.op    = OP_MUL_LOAD;
                        dcmd.min   = MIN_LEN;
                        state_next = S_MUL;
                    end else if (cnt_bad) begin
                        rst_next   = ST_COUNT;
                        state_next = S_OUT;
                    end else if (in_cmd == CMD_AAD) begin
                        dcmd.op      = OP_MUL_LOAD;
                        dcmd.min     = MIN_AAD;
                        partial_next = (in_count < 5'd16);
                        state_next   = S_MUL;
                    end else begin
                        dcmd.op      = OP_AES_LOAD;
                        dcmd.ain     = AIN_CTR;
                        phase_next   = PH_TEXT;
                        partial_next = (in_count < 5'd16);
                        state_next   = S_AES_CTR;
                    end
                end
            end
            S_AES_H:
            begin
                if (dstat.aes_done) begin
                    dcmd.save_h = 1'b1;
                    dcmd.op     = OP_AES_LOAD;
                    dcmd.ain    = AIN_MASK;
                    state_next  = S_AES_MASK;
                end else begin
                    dcmd.op = OP_AES_ROUND;
                end
            end
            S_AES_MASK:
            begin
                if (dstat.aes_done) begin
                    dcmd.save_mask = 1'b1;
                    dcmd.start_msg = 1'b1;
                    phase_next     = PH_AAD;
                    partial_next   = 1'b0;
                    state_next     = S_OUT;
                end else begin
                    dcmd.op = OP_AES_ROUND;
                end
            end
            S_AES_CTR:
            begin
                if (dstat.aes_done) begin
                    dcmd.make_text = 1'b1;
                    dcmd.op        = OP_MUL_LOAD;
                    dcmd.min       = MIN_TEXT;
                    state_next     = S_MUL;
                end else begin
                    dcmd.op = OP_AES_ROUND;
                end
            end
            S_MUL:
            begin
                dcmd.op = OP_MUL_STEP;
                if (dstat.mul_done) begin
                    state_next = (cmd_reg == CMD_FINISH) ? S_TAG : S_OUT;
                    if (cmd_reg == CMD_TEXT) begin
                        res_next  = text_out;
                        rcnt_next = cnt_reg;
                    end
                end
            end
            S_TAG:
            begin
                if (decrypt) begin
                    if (tag_out != data_reg) begin
                        rst_next = ST_MISMATCH;
                    end
                end else begin
                    res_next  = tag_out;
                    rcnt_next = 5'd16;
                    rtag_next = 1'b1;
                end
                phase_next   = PH_IDLE;
                partial_next = 1'b0;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready) begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            phase_reg   <= PH_IDLE;
            partial_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            partial_reg <= partial_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        data_reg <= data_next;
        cnt_reg  <= cnt_next;
        res_reg  <= res_next;
        rcnt_reg <= rcnt_next;
        rtag_reg <= rtag_next;
        rst_reg  <= rst_next;
    end

    assign out_data   = res_reg;
    assign out_count  = rcnt_reg;
    assign out_tag    = rtag_reg;
    assign out_status = rst_reg;
    // While idle the datapath sees the incoming transaction directly.
    assign hold_data  = (state_reg == S_IDLE) ? in_data : data_reg;
    assign hold_count = (state_reg == S_IDLE) ? in_count : cnt_reg;

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("Input and output open together");
    a_tag_full: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_tag) |-> (out_count == 5'd16 && out_status == ST_OK))
        else $error("Tag transaction malformed");
    a_err_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_status != ST_OK) |-> (out_count == '0 && !out_tag))
        else $error("Error transaction carries data");
    a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TAG) |=> phase_reg == PH_IDLE)
        else $error("Finish left a message open");

endmodule

// File: sv/aes128_gcm_engine_core.sv
// AES-128-GCM engine top level: register file, controller and datapath.
// Start runs AES for H and the mask; a text chunk runs AES on the counter, then
// GHASH; AAD and finish run GHASH alone; errors go straight to the result. One
// item at a time, taken in the cycle after the last result is accepted, with one
// AES round and one GHASH bit per cycle; round unit and multiplier are shared.
// Reset (rst_n, asynchronous) clears registers, subkey, mask and returns idle.
`timescale 1ns / 1ps
module aes128_gcm_engine_core
    import agcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    agcm_if.sink                 in_ch,
    agcm_if.source               out_ch,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [AddrWidth-1:0] paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready
);

    logic [63:0] key_high_reg, key_low_reg, nonce_high_reg;
    logic [31:0] nonce_low_reg;
    logic        decrypt_reg;
    logic        wr_en;

    dp_cmd_t               dcmd;
    dp_status_t            dstat;
    logic [127:0]          text_out, tag_out, hold_data, out_data;
    logic [CountWidth-1:0] hold_count, out_count;
    logic                  out_tag;
    status_t               out_status;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            nonce_high_reg <= '0;
            nonce_low_reg  <= '0;
            decrypt_reg    <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr)
                REG_KEY_HIGH:   key_high_reg   <= pwdata;
                REG_KEY_LOW:    key_low_reg    <= pwdata;
                REG_NONCE_HIGH: nonce_high_reg <= pwdata;
                REG_NONCE_LOW:  nonce_low_reg  <= pwdata[31:0];
                REG_DECRYPT:    decrypt_reg    <= pwdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            REG_KEY_HIGH:   prdata = key_high_reg;
            REG_KEY_LOW:    prdata = key_low_reg;
            REG_NONCE_HIGH: prdata = nonce_high_reg;
            REG_NONCE_LOW:  prdata = {32'd0, nonce_low_reg};
            REG_DECRYPT:    prdata = {63'd0, decrypt_reg};
            default:        prdata = '0;
        endcase
    end

    agcm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_cmd     (cmd_t'(in_ch.data[134:133])),
        .in_data    (in_ch.data[132:CountWidth]),
        .in_count   (in_ch.data[CountWidth-1:0]),
        .decrypt    (decrypt_reg),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_data   (out_data),
        .out_count  (out_count),
        .out_tag    (out_tag),
        .out_status (out_status),
        .dcmd       (dcmd),
        .dstat      (dstat),
        .text_out   (text_out),
        .tag_out    (tag_out),
        .hold_data  (hold_data),
        .hold_count (hold_count)
    );

    agcm_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (dcmd),
        .stat     (dstat),
        .key      ({key_high_reg, key_low_reg}),
        .nonce    ({nonce_high_reg, nonce_low_reg}),
        .decrypt  (decrypt_reg),
        .in_data  (hold_data),
        .in_count (hold_count),
        .text_out (text_out),
        .tag_out  (tag_out)
    );

    assign out_ch.data = {out_data, out_count, out_tag, out_status};

endmodule
